/* rtl/nfcd_pkg.sv */
// Shared types and constants for the NOR flash command decoder.
package nfcd_pkg;

	localparam int unsigned WORD_ADDR_W = 12;
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned EVENT_W     = 3;

	localparam logic [7:0] CMD_RESET   = 8'hF0;
	localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_ERASE   = 8'h80;
	localparam logic [7:0] CMD_CHIP    = 8'h10;

	localparam logic [31:0] UNLOCK_ADDR_A = 32'h0000_0555;
	localparam logic [31:0] UNLOCK_ADDR_B = 32'h0000_02AA;

	localparam logic [DATA_W-1:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_AA        = 3'd1,
		PH_AA55      = 3'd2,
		PH_PROG      = 3'd3,
		PH_ERS_SETUP = 3'd4,
		PH_ERS_AA    = 3'd5,
		PH_ERS_AA55  = 3'd6
	} phase_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE  = 3'd0,
		EV_ADV   = 3'd1,
		EV_PROG  = 3'd2,
		EV_ERASE = 3'd3,
		EV_RESET = 3'd4,
		EV_ABORT = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic clr;
	} ctl_cmd_t;

	typedef struct packed {
		logic erase;
		logic clr_last;
	} dp_sts_t;

endpackage

/* rtl/nfcd_req_if.sv */
// Request channel: bus access command, word address and write data.
interface nfcd_req_if import nfcd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [WORD_ADDR_W-1:0] word_addr;
	logic [DATA_W-1:0]      write_data;

	modport source(output valid, cmd, word_addr, write_data, input ready);
	modport sink(input valid, cmd, word_addr, write_data, output ready);
endinterface

/* rtl/nfcd_rsp_if.sv */
// Response channel: read data and event code.
interface nfcd_rsp_if import nfcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	logic [EVENT_W-1:0] event_res;

	modport source(output valid, read_data, event_res, input ready);
	modport sink(input valid, read_data, event_res, output ready);
endinterface

/* rtl/nfcd_ctrl.sv */
// Controller: sequences capture, execute and array clearing sweeps.
module nfcd_ctrl import nfcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t ctl
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free)
					state_d = sts.erase ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctl       = '0;
		unique case (state_q)
			ST_CLEAR: ctl.clr = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				ctl.cap   = req_valid;
			end
			ST_EXEC:  ctl.exec = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.exec)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/nfcd_dpath.sv */
// Datapath: word store, unlock sequence decode and response register.
module nfcd_dpath import nfcd_pkg::*; #(
	parameter int unsigned ADDR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               ctl,
	output dp_sts_t                sts,
	input  logic                   cmd,
	input  logic [WORD_ADDR_W-1:0] word_addr,
	input  logic [DATA_W-1:0]      write_data,
	output logic [DATA_W-1:0]      read_data,
	output logic [EVENT_W-1:0]     event_res
);

	localparam int unsigned DEPTH = 1 << ADDR_BITS;

	logic [DATA_W-1:0]    mem [DEPTH];
	logic [DATA_W-1:0]    mem_rd_q;
	logic                 req_cmd_q;
	logic [ADDR_BITS-1:0] req_addr_q;
	logic [DATA_W-1:0]    req_data_q;
	logic [ADDR_BITS-1:0] clr_idx_q;
	phase_t               phase_q;
	logic [DATA_W-1:0]    rsp_data_q;
	event_t               rsp_event_q;

	logic [ADDR_BITS-1:0] cap_addr;
	logic                 at_a;
	logic                 at_b;
	logic [7:0]           cbyte;
	phase_t               phase_d;
	event_t               ev_d;
	logic                 prog_d;
	logic                 erase_d;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_wa;
	logic [DATA_W-1:0]    mem_wd;

	assign cap_addr = ADDR_BITS'(32'(word_addr));
	assign at_a     = req_addr_q == ADDR_BITS'(UNLOCK_ADDR_A);
	assign at_b     = req_addr_q == ADDR_BITS'(UNLOCK_ADDR_B);
	assign cbyte    = req_data_q[7:0];

	always_comb begin
		phase_d = phase_q;
		ev_d    = EV_NONE;
		prog_d  = 1'b0;
		erase_d = 1'b0;
		if (!req_cmd_q) begin
			phase_d = phase_q;
		end else if (phase_q == PH_PROG) begin
			prog_d  = 1'b1;
			phase_d = PH_IDLE;
			ev_d    = EV_PROG;
		end else if (cbyte == CMD_RESET) begin
			phase_d = PH_IDLE;
			ev_d    = EV_RESET;
		end else begin
			phase_d = PH_IDLE;
			ev_d    = EV_ABORT;
			unique case (phase_q)
				PH_AA: begin
					if (at_b && cbyte == CMD_UNLOCK2) begin
						phase_d = PH_AA55;
						ev_d    = EV_ADV;
					end
				end
				PH_AA55: begin
					if (at_a && cbyte == CMD_PROGRAM) begin
						phase_d = PH_PROG;
						ev_d    = EV_ADV;
					end else if (at_a && cbyte == CMD_ERASE) begin
						phase_d = PH_ERS_SETUP;
						ev_d    = EV_ADV;
					end
				end
				PH_ERS_SETUP: begin
					if (at_a && cbyte == CMD_UNLOCK1) begin
						phase_d = PH_ERS_AA;
						ev_d    = EV_ADV;
					end
				end
				PH_ERS_AA: begin
					if (at_b && cbyte == CMD_UNLOCK2) begin
						phase_d = PH_ERS_AA55;
						ev_d    = EV_ADV;
					end
				end
				PH_ERS_AA55: begin
					if (at_a && cbyte == CMD_CHIP) begin
						erase_d = 1'b1;
						ev_d    = EV_ERASE;
					end
				end
				default: begin
					// idle and unused phase: a stray write is ignored
					if (at_a && cbyte == CMD_UNLOCK1) begin
						phase_d = PH_AA;
						ev_d    = EV_ADV;
					end else begin
						ev_d = EV_NONE;
					end
				end
			endcase
		end
	end

	assign mem_we = ctl.clr || (ctl.exec && prog_d);
	assign mem_wa = ctl.clr ? clr_idx_q : req_addr_q;
	assign mem_wd = ctl.clr ? ERASED_WORD : (mem_rd_q & req_data_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (ctl.cap)
			mem_rd_q <= mem[cap_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			req_cmd_q  <= cmd;
			req_addr_q <= cap_addr;
			req_data_q <= write_data;
		end
		if (ctl.exec) begin
			rsp_data_q  <= req_cmd_q ? '0 : mem_rd_q;
			rsp_event_q <= ev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			clr_idx_q <= '0;
		end else begin
			if (ctl.exec)
				phase_q <= phase_d;
			if (ctl.clr)
				clr_idx_q <= clr_idx_q + ADDR_BITS'(1);
		end
	end

	assign sts.erase    = erase_d;
	assign sts.clr_last = &clr_idx_q;
	assign read_data    = rsp_data_q;
	assign event_res    = rsp_event_q;

endmodule

/* rtl/nor_flash_command_decoder_core.sv */
// Top level of the NOR flash command decoder.
// A request is captured in the idle state; its response is registered in the
// execute state once the previous response is taken. Requests do not overlap,
// and a full-array store sweep stalls requests; after a chip erase it writes all
// 2^ADDR_BITS words (4096 at the default). Reset: the sequence returns to read mode
// and the same sweep fills the store with ones before the first request is accepted.
module nor_flash_command_decoder_core import nfcd_pkg::*; #(
	parameter int unsigned ADDR_BITS = 12
) (
	input logic       clk,
	input logic       arst_n,
	nfcd_req_if.sink  req,
	nfcd_rsp_if.source rsp
);

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	nfcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	nfcd_dpath #(
		.ADDR_BITS (ADDR_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (req.cmd),
		.word_addr  (req.word_addr),
		.write_data (req.write_data),
		.read_data  (rsp.read_data),
		.event_res  (rsp.event_res)
	);

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !rsp.valid) |=> ##1 rsp.valid)
		else $error("response missing after request");

	a_erase_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp.valid) && rsp.event_res == EV_ERASE) |-> !req.ready)
		else $error("request taken during erase sweep");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_res != EV_NONE) |-> rsp.read_data == '0)
		else $error("write response carries data");

endmodule
